// ----- hw/rtl/stdu_pkg.sv -----
// shared types and constants for the scratchpad temperature decode unit
package stdu_pkg;

  localparam int unsigned SCRATCHPAD_LEN = 9;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned CRC_STEPS      = 8;
  localparam int unsigned DIV_STEPS      = 16;

  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(SCRATCHPAD_LEN - 1);
  localparam logic [7:0]       CRC_POLY     = 8'h8C;
  localparam logic [15:0]      DISCONNECTED = 16'hE480;  // -7040
  localparam logic [15:0]      LEGACY_BIAS  = 16'd32;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_LINK = 2'd1,
    STATUS_ZERO = 2'd2,
    STATUS_CRC  = 2'd3
  } stdu_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_DIV
  } stdu_state_t;

endpackage

// ----- hw/rtl/scratchpad_temperature_decode_unit.sv -----
// scratchpad byte collector with serial crc-8 and serial divider for temperature decode
// bytes 0..7: one transfer each, then a bit-serial crc over the byte with in_stall high
// byte 8: result registered on its transfer, or after the divider for the legacy interpolation,
//   a restoring divider that gives one quotient bit per cycle
// the result register frees the input for the next pad, but byte 8 stalls while a result is held
// synchronous active-low reset clears byte count, crc, flags, sequencer and result valid
module scratchpad_temperature_decode_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_legacy_family,
  input  logic               in_link_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_temperature_raw,
  output logic [1:0]         out_status
);

  stdu_pkg::stdu_state_t state_r, state_nxt;

  logic [stdu_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [stdu_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        nz_r, nz_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [7:0]  lsb_r, lsb_nxt;
  logic [7:0]  msb_r, msb_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [7:0]  cpc_r, cpc_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [15:0] base_r, base_nxt;
  logic        neg_r, neg_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_temp_r, out_temp_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  logic        in_xfer;
  logic        nz_any;
  logic        last_byte;
  logic        go_div;
  stdu_pkg::stdu_status_t status;
  logic        crc_mix;
  logic [8:0]  diff9;
  logic [8:0]  mag9;
  logic [8:0]  shifted;
  logic [9:0]  trial;
  logic [15:0] q_final;
  logic [15:0] q_signed;
  logic        crc_done;
  logic        div_done;

  assign last_byte = (idx_r == stdu_pkg::LAST_IDX);
  assign in_stall  = (state_r != stdu_pkg::ST_IDLE) || (last_byte && out_valid_r);
  assign in_xfer   = in_valid && !in_stall;
  assign nz_any    = nz_r || (in_data_byte != 8'd0);
  assign crc_done  = (cnt_r == stdu_pkg::CNT_W'(stdu_pkg::CRC_STEPS - 1));
  assign div_done  = (cnt_r == stdu_pkg::CNT_W'(stdu_pkg::DIV_STEPS - 1));

  // status priority: link, then all-zero, then crc
  always_comb begin
    if (!in_link_ok) begin
      status = stdu_pkg::STATUS_LINK;
    end else if (!nz_any) begin
      status = stdu_pkg::STATUS_ZERO;
    end else if (crc_r != in_data_byte) begin
      status = stdu_pkg::STATUS_CRC;
    end else begin
      status = stdu_pkg::STATUS_OK;
    end
  end

  assign go_div = (status == stdu_pkg::STATUS_OK) && in_legacy_family && (cpc_r != 8'd0);

  assign crc_mix = crc_r[0] ^ sh_r[0];

  // signed count difference, divided as a magnitude
  assign diff9 = {1'b0, cpc_r} - {1'b0, remain_r};
  assign mag9  = diff9[8] ? (9'd0 - diff9) : diff9;

  assign shifted  = {rem_r, dvd_r[15]};
  assign trial    = {1'b0, shifted} - {2'b00, cpc_r};
  assign q_final  = {dvd_r[14:0], ~trial[9]};
  assign q_signed = neg_r ? (16'd0 - q_final) : q_final;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stdu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (!last_byte) begin
            state_nxt = stdu_pkg::ST_CRC;
          end else if (go_div) begin
            state_nxt = stdu_pkg::ST_DIV;
          end
        end
      end
      stdu_pkg::ST_CRC: begin
        if (crc_done) begin
          state_nxt = stdu_pkg::ST_IDLE;
        end
      end
      stdu_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = stdu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stdu_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and result register
  always_comb begin
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    crc_nxt        = crc_r;
    nz_nxt         = nz_r;
    sh_nxt         = sh_r;
    lsb_nxt        = lsb_r;
    msb_nxt        = msb_r;
    remain_nxt     = remain_r;
    cpc_nxt        = cpc_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    base_nxt       = base_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r;
    out_temp_nxt   = out_temp_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      stdu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (!last_byte) begin
            nz_nxt  = nz_any;
            sh_nxt  = in_data_byte;
            cnt_nxt = '0;
            idx_nxt = idx_r + stdu_pkg::IDX_W'(1);
            case (idx_r)
              4'd0:    lsb_nxt    = in_data_byte;
              4'd1:    msb_nxt    = in_data_byte;
              4'd6:    remain_nxt = in_data_byte;
              4'd7:    cpc_nxt    = in_data_byte;
              default: ;
            endcase
          end else begin
            idx_nxt = '0;
            crc_nxt = '0;
            nz_nxt  = 1'b0;
            if (go_div) begin
              cnt_nxt  = '0;
              rem_nxt  = '0;
              dvd_nxt  = {1'b0, mag9[7:0], 7'd0};
              neg_nxt  = diff9[8];
              base_nxt = {msb_r[1:0], lsb_r[7:1], 7'd0} - stdu_pkg::LEGACY_BIAS;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = status;
              if (status == stdu_pkg::STATUS_OK) begin
                out_temp_nxt = {msb_r[4:0], lsb_r, 3'd0};
              end else begin
                out_temp_nxt = stdu_pkg::DISCONNECTED;
              end
            end
          end
        end
      end
      stdu_pkg::ST_CRC: begin
        crc_nxt = {1'b0, crc_r[7:1]} ^ (crc_mix ? stdu_pkg::CRC_POLY : 8'd0);
        sh_nxt  = {1'b0, sh_r[7:1]};
        cnt_nxt = cnt_r + stdu_pkg::CNT_W'(1);
      end
      stdu_pkg::ST_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_nxt = trial[9] ? shifted[7:0] : trial[7:0];
        dvd_nxt = q_final;
        cnt_nxt = cnt_r + stdu_pkg::CNT_W'(1);
        if (div_done) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stdu_pkg::STATUS_OK;
          out_temp_nxt   = base_r + q_signed;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stdu_pkg::ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      crc_r       <= '0;
      nz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      nz_r        <= nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r         <= sh_nxt;
    lsb_r        <= lsb_nxt;
    msb_r        <= msb_nxt;
    remain_r     <= remain_nxt;
    cpc_r        <= cpc_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    base_r       <= base_nxt;
    neg_r        <= neg_nxt;
    out_temp_r   <= out_temp_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_temperature_raw = out_temp_r;
  assign out_status          = out_status_r;

endmodule
